>>> sv/bvs_pkg.sv
package bvs_pkg;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 8;
    localparam int MEMBER_W = 6;
    localparam int MAXV_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_ENUM   = 2'd3;

    localparam logic [MAXV_W-1:0] MAXV_RESET = 6'd63;

    typedef struct packed {
        logic exec;
        logic scan_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic hit;
        logic pending;
        logic scan_end;
    } t_status;

endpackage

>>> sv/bvs_ctrl.sv
module bvs_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [bvs_pkg::OP_W-1:0] i_op,
    input  bvs_pkg::t_status         i_status,
    output bvs_pkg::t_cmd            o_cmd,
    output logic                     o_stall
);
    import bvs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_ready;

    assign w_ready         = (r_state == S_IDLE) && i_status.out_free;
    assign o_stall         = !w_ready;
    assign o_cmd.exec      = i_valid && w_ready;
    assign o_cmd.scan_step = (r_state == S_SCAN)
                           && !(i_status.hit && i_status.pending && !i_status.out_free);
    assign o_cmd.flush     = (r_state == S_FLUSH) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.exec && (i_op == OP_ENUM)) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (o_cmd.scan_step && i_status.scan_end) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (o_cmd.flush) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/bvs_dp.sv
module bvs_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bvs_pkg::t_cmd                i_cmd,
    output bvs_pkg::t_status             o_status,
    input  logic [bvs_pkg::OP_W-1:0]     i_op,
    input  logic signed [bvs_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_cfg_wr_en,
    input  logic [bvs_pkg::MAXV_W-1:0]   i_cfg_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [bvs_pkg::MEMBER_W-1:0] o_member,
    output logic                         o_member_valid,
    output logic                         o_range_error,
    output logic [bvs_pkg::COUNT_W-1:0]  o_member_count,
    output logic                         o_last
);
    import bvs_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] r_bits;
    logic [CAPACITY-1:0] n_bits;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [MAXV_W-1:0]   r_maxv;
    logic [IDX_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    n_ptr;
    logic [IDX_W-1:0]    r_pend;
    logic [IDX_W-1:0]    n_pend;
    logic                r_pend_vld;
    logic                n_pend_vld;

    logic                r_o_valid;
    logic                n_o_valid;
    logic [MEMBER_W-1:0] r_o_member;
    logic [MEMBER_W-1:0] n_o_member;
    logic                r_o_mvalid;
    logic                n_o_mvalid;
    logic                r_o_rerr;
    logic                n_o_rerr;
    logic [COUNT_W-1:0]  r_o_count;
    logic [COUNT_W-1:0]  n_o_count;
    logic                r_o_last;
    logic                n_o_last;

    logic [IDX_W-1:0]    w_lim;
    logic [VALUE_W-1:0]  w_raw;
    logic [IDX_W-1:0]    w_idx;
    logic                w_in_range;
    logic                w_hit;
    logic                w_emit;

    always_comb begin
        if (COUNT_W'(r_maxv) > COUNT_W'(CAPACITY - 1)) w_lim = IDX_W'(CAPACITY - 1);
        else w_lim = IDX_W'(r_maxv);
    end

    assign w_raw      = i_value;
    assign w_idx      = w_raw[IDX_W-1:0];
    assign w_in_range = !w_raw[VALUE_W-1] && (w_raw <= VALUE_W'(w_lim));
    assign w_hit      = r_bits[r_ptr];

    assign o_status.out_free = !r_o_valid || !i_stall;
    assign o_status.hit      = w_hit;
    assign o_status.pending  = r_pend_vld;
    assign o_status.scan_end = (r_ptr == w_lim);

    always_comb begin
        n_bits     = r_bits;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        w_emit     = 1'b0;
        n_o_member = r_o_member;
        n_o_mvalid = r_o_mvalid;
        n_o_rerr   = r_o_rerr;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;

        if (i_cmd.exec) begin
            case (i_op) inside
                OP_CLEAR: begin
                    n_bits     = '0;
                    n_count    = '0;
                    w_emit     = 1'b1;
                    n_o_member = '0;
                    n_o_mvalid = 1'b0;
                    n_o_rerr   = 1'b0;
                    n_o_count  = '0;
                    n_o_last   = 1'b1;
                end
                OP_INSERT, OP_FIND: begin
                    w_emit   = 1'b1;
                    n_o_last = 1'b1;
                    if (!w_in_range) begin
                        n_o_member = '0;
                        n_o_mvalid = 1'b0;
                        n_o_rerr   = 1'b1;
                    end else begin
                        n_o_member = MEMBER_W'(w_idx);
                        n_o_rerr   = 1'b0;
                        if (i_op == OP_INSERT) begin
                            n_o_mvalid = 1'b1;
                            if (!r_bits[w_idx]) begin
                                n_bits[w_idx] = 1'b1;
                                n_count       = r_count + COUNT_W'(1);
                            end
                        end else begin
                            n_o_mvalid = r_bits[w_idx];
                        end
                    end
                    n_o_count = n_count;
                end
                default: begin
                    n_ptr      = '0;
                    n_pend_vld = 1'b0;
                end
            endcase
        end

        if (i_cmd.scan_step) begin
            if (w_hit) begin
                if (r_pend_vld) begin
                    w_emit     = 1'b1;
                    n_o_member = MEMBER_W'(r_pend);
                    n_o_mvalid = 1'b1;
                    n_o_rerr   = 1'b0;
                    n_o_count  = r_count;
                    n_o_last   = 1'b0;
                end
                n_pend     = r_ptr;
                n_pend_vld = 1'b1;
            end
            if (r_ptr != w_lim) n_ptr = r_ptr + IDX_W'(1);
        end

        if (i_cmd.flush) begin
            w_emit     = 1'b1;
            n_o_member = r_pend_vld ? MEMBER_W'(r_pend) : '0;
            n_o_mvalid = r_pend_vld;
            n_o_rerr   = 1'b0;
            n_o_count  = r_count;
            n_o_last   = 1'b1;
        end

        if (i_cfg_wr_en) begin
            n_bits  = '0;
            n_count = '0;
        end

        if (w_emit) n_o_valid = 1'b1;
        else if (!i_stall) n_o_valid = 1'b0;
        else n_o_valid = r_o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits     <= '0;
            r_count    <= '0;
            r_maxv     <= MAXV_RESET;
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_bits     <= n_bits;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_o_valid  <= n_o_valid;
            if (i_cfg_wr_en) r_maxv <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pend     <= n_pend;
        r_o_member <= n_o_member;
        r_o_mvalid <= n_o_mvalid;
        r_o_rerr   <= n_o_rerr;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_valid        = r_o_valid;
    assign o_member       = r_o_member;
    assign o_member_valid = r_o_mvalid;
    assign o_range_error  = r_o_rerr;
    assign o_member_count = r_o_count;
    assign o_last         = r_o_last;

endmodule

>>> sv/bitmap_set_with_enumeration.sv
// channel   | valid    | stall    | payload
// request   | i_valid  | o_stall  | i_op, i_value
// result    | o_valid  | i_stall  | o_member, o_member_valid, o_range_error,
//           |          |          | o_member_count, o_last
// config    | i_cfg_wr_en          | i_cfg_data
//
// Clear, insert and find load their result into the output register on acceptance.
// Enumerate walks the bitmap one bit a cycle from 0 to the limit while no held result
// pauses the walk.
// Reset empties the set, zeroes the count and sets the limit to 63.
// A held result blocks new requests and pauses the walk at the next member or the
// final result until it is taken.
module bitmap_set_with_enumeration #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [bvs_pkg::OP_W-1:0]           i_op,
    input  logic signed [bvs_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [bvs_pkg::MEMBER_W-1:0]       o_member,
    output logic                               o_member_valid,
    output logic                               o_range_error,
    output logic [bvs_pkg::COUNT_W-1:0]        o_member_count,
    output logic                               o_last,
    input  logic                               i_cfg_wr_en,
    input  logic [bvs_pkg::MAXV_W-1:0]         i_cfg_data
);
    import bvs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    bvs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    bvs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_member       (o_member),
        .o_member_valid (o_member_valid),
        .o_range_error  (o_range_error),
        .o_member_count (o_member_count),
        .o_last         (o_last)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_member_count <= COUNT_W'(CAPACITY)))
        else $error("member count above capacity");

    a_mid_is_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_member_valid && !o_range_error))
        else $error("non-final result is not a member");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (!o_member_valid && o_member == '0 && o_last))
        else $error("range error result carries a member");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_op == OP_CLEAR)
        |=> (o_valid && o_last && o_member_count == '0))
        else $error("clear did not give an empty result");

endmodule

>>> tb/sv/bitmap_set_with_enumeration_test.sv
`timescale 1ns / 100ps
module bitmap_set_with_enumeration_test;
    import bvs_pkg::*;

    localparam int SET_CAP         = 64;
    localparam int DRAIN_CYCLES    = SET_CAP + 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 25;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic [MEMBER_W-1:0] member;
        logic                member_valid;
        logic                range_error;
        logic [COUNT_W-1:0]  member_count;
        logic                last;
    } t_result;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic [OP_W-1:0]           i_op        = OP_CLEAR;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic                      i_stall     = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [MAXV_W-1:0]         i_cfg_data  = '0;
    logic                      o_stall;
    logic                      o_valid;
    logic [MEMBER_W-1:0]       o_member;
    logic                      o_member_valid;
    logic                      o_range_error;
    logic [COUNT_W-1:0]        o_member_count;
    logic                      o_last;

    t_request           pending_reqs[$];
    t_result            expected_results[$];
    logic [SET_CAP-1:0] set_bits      = '0;
    logic [COUNT_W-1:0] set_count     = '0;
    logic [MAXV_W-1:0]  set_max       = MAXV_RESET;
    logic               req_accepted  = 1'b0;
    int                 mismatch_count = 0;
    int                 item_total    = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    logic               hold_off_trig = 1'b0;
    logic               hold_off_seen = 1'b0;
    int                 hold_off_left = 0;

    bitmap_set_with_enumeration #(
        .CAPACITY(SET_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_member      (o_member),
        .o_member_valid(o_member_valid),
        .o_range_error (o_range_error),
        .o_member_count(o_member_count),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_result make_result(input logic [MEMBER_W-1:0] member,
                                            input logic hit, input logic err,
                                            input logic last);
        t_result res;
        res.member       = member;
        res.member_valid = hit;
        res.range_error  = err;
        res.member_count = set_count;
        res.last         = last;
        return res;
    endfunction

    task automatic predict_results(input t_request req);
        int   lim;
        int   n;
        int   k;
        int   i;
        logic in_range;
        lim = (int'(set_max) > SET_CAP - 1) ? SET_CAP - 1 : int'(set_max);
        in_range = !req.value[VALUE_W-1] && (int'(req.value) <= lim);
        case (req.op) inside
            OP_CLEAR: begin
                set_bits  = '0;
                set_count = '0;
                expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
            end
            OP_INSERT, OP_FIND: begin
                if (!in_range) begin
                    expected_results.push_back(make_result('0, 1'b0, 1'b1, 1'b1));
                end else begin
                    if (req.op == OP_INSERT && !set_bits[req.value[MEMBER_W-1:0]]) begin
                        set_bits[req.value[MEMBER_W-1:0]] = 1'b1;
                        set_count = set_count + COUNT_W'(1);
                    end
                    expected_results.push_back(make_result(req.value[MEMBER_W-1:0],
                        set_bits[req.value[MEMBER_W-1:0]], 1'b0, 1'b1));
                end
            end
            OP_ENUM: begin
                n = 0;
                for (i = 0; i <= lim; i++) n += set_bits[i];
                if (n == 0) begin
                    expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
                end else begin
                    k = 0;
                    for (i = 0; i <= lim; i++) begin
                        if (set_bits[i]) begin
                            k++;
                            expected_results.push_back(make_result(MEMBER_W'(i), 1'b1,
                                1'b0, k == n));
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result  wanted;
        t_request taken;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual member %0d",
                             $time, o_member);
                    mismatch_count++;
                end else begin
                    wanted = expected_results.pop_front();
                    check_field("member", 8'(wanted.member), 8'(o_member));
                    check_field("member_valid", 8'(wanted.member_valid),
                                8'(o_member_valid));
                    check_field("range_error", 8'(wanted.range_error),
                                8'(o_range_error));
                    check_field("member_count", 8'(wanted.member_count),
                                8'(o_member_count));
                    check_field("last", 8'(wanted.last), 8'(o_last));
                end
            end
            if (i_valid && !o_stall) begin
                taken.op    = i_op;
                taken.value = i_value;
                predict_results(taken);
            end
            if (i_cfg_wr_en) begin
                set_max   = i_cfg_data;
                set_bits  = '0;
                set_count = '0;
            end
        end
        req_accepted <= i_rst_n && i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        t_request next_req;
        if (!i_valid || req_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                i_valid <= 1'b1;
                i_op    <= next_req.op;
                i_value <= next_req.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_trig != hold_off_seen) begin
            hold_off_seen <= hold_off_trig;
            hold_off_left <= HOLD_OFF_CYCLES;
            i_stall       <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_stall       <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic add_req(input logic [OP_W-1:0] kind, input int val);
        t_request req;
        req.op    = kind;
        req.value = val[VALUE_W-1:0];
        pending_reqs.push_back(req);
        item_total++;
    endtask

    function automatic int pick_value(input int lim);
        if ($urandom_range(9) != 0) return $urandom_range(0, lim);
        return $urandom_range(0, 255);
    endfunction

    task automatic add_set_sequence(input int lim);
        int n;
        add_req(OP_CLEAR, $urandom_range(0, 255));
        n = ($urandom_range(7) == 0) ? $urandom_range(lim + 1, 2 * lim + 2)
                                     : $urandom_range(0, 6);
        repeat (n) add_req(OP_INSERT, pick_value(lim));
        repeat ($urandom_range(0, 3)) add_req(OP_FIND, pick_value(lim));
        add_req(OP_ENUM, $urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_max(input int val);
        @(negedge i_clk);
        i_cfg_data  <= val[MAXV_W-1:0];
        i_cfg_wr_en <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase_max[8];
        int ph;
        int lim;
        int v;
        int target;
        phase_max = '{63, 0, 7, 63, 31, 1, 0, 63};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_req(OP_ENUM, 0);
        add_req(OP_FIND, 0);
        add_req(OP_INSERT, 0);
        add_req(OP_INSERT, 63);
        add_req(OP_INSERT, 0);
        add_req(OP_FIND, 0);
        add_req(OP_FIND, 5);
        add_req(OP_FIND, -1);
        add_req(OP_INSERT, -128);
        add_req(OP_INSERT, 127);
        add_req(OP_INSERT, 64);
        add_req(OP_FIND, 64);
        add_req(OP_ENUM, 0);
        add_req(OP_CLEAR, 0);
        add_req(OP_ENUM, 0);
        wait_drained();

        write_max(0);
        add_req(OP_ENUM, 0);
        add_req(OP_INSERT, 1);
        add_req(OP_INSERT, 0);
        add_req(OP_FIND, 0);
        add_req(OP_ENUM, 0);
        add_req(OP_INSERT, -1);
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            lim = (ph == 6) ? $urandom_range(0, 63) : phase_max[ph];
            write_max(lim);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            if (ph == 3) begin
                // hold the result side while a full set of requests queues up
                hold_off_trig = ~hold_off_trig;
                add_req(OP_CLEAR, 0);
                for (v = 63; v >= 0; v--) add_req(OP_INSERT, v);
                add_req(OP_ENUM, 0);
                add_req(OP_FIND, 63);
                add_req(OP_INSERT, 17);
                add_req(OP_ENUM, 0);
                wait_drained();
            end
            target = item_total + PHASE_ITEMS;
            while (item_total < target) begin
                if ($urandom_range(9) < 7)
                    add_set_sequence(lim);
                else
                    add_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 255));
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[bitmap_set_with_enumeration] OK");
        else
            $display("[bitmap_set_with_enumeration] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[bitmap_set_with_enumeration] ERROR");
        $finish;
    end

endmodule
